[hdl/mkc_pkg.sv]
`timescale 1ns / 1ps
package mkc_pkg;

  localparam int MAX_WIDTH    = 256;
  localparam int MAX_KERNELS  = 8;
  localparam int MAX_KSIZE    = 5;
  localparam int HEIGHT_LIMIT = 256;

  localparam int LINE_SLOTS = (MAX_KSIZE > 1) ? MAX_KSIZE - 1 : 1;
  localparam int SLOT_W     = (LINE_SLOTS > 1) ? $clog2(LINE_SLOTS) : 1;
  localparam int ADDR_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int KSEL_W     = (MAX_KERNELS > 1) ? $clog2(MAX_KERNELS) : 1;
  localparam int KN_W       = $clog2(MAX_KERNELS + 1);
  localparam int KS_W       = $clog2(MAX_KSIZE + 1);
  localparam int IDX_W      = (MAX_KSIZE > 1) ? $clog2(MAX_KSIZE) : 1;
  localparam int CELLS      = MAX_KSIZE * MAX_KSIZE;

  localparam int PIX_W  = 8;
  localparam int PROD_W = 2 * PIX_W;
  localparam int SUM_W  = 20;
  localparam int CNT_W  = 9;
  localparam int LINE_W = LINE_SLOTS * PIX_W;

  // item kinds
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_PIXEL = 2'd1;
  localparam logic [1:0] KIND_FRAME = 2'd2;

  // register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ROWS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_COLS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_COUNT = 3'd4;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_INJ,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic [2:0]              kernel_sel;
    logic [2:0]              weight_row;
    logic [2:0]              weight_col;
    logic signed [PIX_W-1:0] sample;
  } in_t;

  typedef struct packed {
    logic [2:0]              map_index;
    logic [7:0]              out_row;
    logic [7:0]              out_col;
    logic signed [SUM_W-1:0] dot_sum;
    logic                    last;
  } out_t;

  // partial sum travelling along the cell chain
  typedef struct packed {
    logic                    valid;
    logic [KSEL_W-1:0]       map;
    logic                    last;
    logic signed [SUM_W-1:0] sum;
  } tok_t;

  // weight write into one cell
  typedef struct packed {
    logic                    en;
    logic [KSEL_W-1:0]       sel;
    logic signed [PIX_W-1:0] value;
  } wload_t;

  typedef logic [MAX_KSIZE-1:0][MAX_KSIZE-1:0][PIX_W-1:0] win_t;

  function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CNT_W-1:0] v, input int hi);
    logic [CNT_W-1:0] r;
    if (v == '0) r = CNT_W'(1);
    else if (int'(v) > hi) r = CNT_W'(hi);
    else r = v;
    return r;
  endfunction

  function automatic logic [KS_W-1:0] clamp_ks(input logic [2:0] v);
    logic [KS_W-1:0] r;
    if (v == '0) r = KS_W'(1);
    else if (int'(v) > MAX_KSIZE) r = KS_W'(MAX_KSIZE);
    else r = KS_W'(v);
    return r;
  endfunction

  function automatic logic [KN_W-1:0] clamp_kn(input logic [3:0] v);
    logic [KN_W-1:0] r;
    if (v == '0) r = KN_W'(1);
    else if (int'(v) > MAX_KERNELS) r = KN_W'(MAX_KERNELS);
    else r = KN_W'(v);
    return r;
  endfunction

endpackage

[hdl/mkc_ram.sv]
`timescale 1ns / 1ps
module mkc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/mkc_cell.sv]
`timescale 1ns / 1ps
module mkc_cell (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             adv,
  input  logic                             tap_en,
  input  logic signed [mkc_pkg::PIX_W-1:0] tap,
  input  mkc_pkg::wload_t                  wl,
  input  mkc_pkg::tok_t                    tok_in,
  output mkc_pkg::tok_t                    tok_out
);
  import mkc_pkg::*;

  // one weight per kernel for this tap position
  logic signed [PIX_W-1:0]  wmem [MAX_KERNELS];
  logic signed [PIX_W-1:0]  w;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  addend;

  always_ff @(posedge clk) begin
    if (wl.en) begin
      wmem[wl.sel] <= wl.value;
    end
  end

  assign w      = wmem[tok_in.map];
  assign prod   = tap * w;
  assign addend = tap_en ? {{(SUM_W-PROD_W){prod[PROD_W-1]}}, prod} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (adv) begin
      tok_out.valid <= tok_in.valid;
    end
    if (adv) begin
      tok_out.map  <= tok_in.map;
      tok_out.last <= tok_in.last;
      tok_out.sum  <= tok_in.sum + addend;
    end
  end

endmodule

[hdl/multi_kernel_valid_conv2d.sv]
`timescale 1ns / 1ps
// channel  direction  payload  handshake
// item     in         in_t     item_valid / item_stall
// result   out        out_t    result_valid / result_stall
// config   in         9 bits   cfg_we / cfg_index / cfg_data
//
// a weight load, frame start or unused kind is taken while idle and leaves the block idle
// a pixel that completes no window passes through the read state back to idle;
// one that does then injects one token per kernel into the mac chain, pausing
// while results stall, and drains until the chain (one cell per kernel tap) is empty
// after reset every word of the line memory is cleared, item_stall held high
// a stalled result freezes the whole chain; the result register lets the next
// item in while the last result of a pixel waits
module multi_kernel_valid_conv2d (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  mkc_pkg::in_t                     item,
  output logic                             result_valid,
  input  logic                             result_stall,
  output mkc_pkg::out_t                    result,
  input  logic                             cfg_we,
  input  logic [mkc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mkc_pkg::CNT_W-1:0]        cfg_data
);
  import mkc_pkg::*;

  // configuration registers, raw values
  logic [CNT_W-1:0] image_width;
  logic [CNT_W-1:0] image_height;
  logic [2:0]       kernel_rows;
  logic [2:0]       kernel_cols;
  logic [3:0]       kernel_count;

  // clamped sizes
  logic [CNT_W-1:0] w_c;
  logic [CNT_W-1:0] h_c;
  logic [KS_W-1:0]  kr;
  logic [KS_W-1:0]  kc;
  logic [KN_W-1:0]  kn;

  state_t st, st_next;

  logic [CNT_W-1:0]  row_count;
  logic [CNT_W-1:0]  col_count;
  logic [SLOT_W-1:0] slot_base;   // row_count modulo the number of line slots

  // pixel being worked on
  logic signed [PIX_W-1:0] px;
  logic [CNT_W-1:0]        pr;
  logic [CNT_W-1:0]        pc;
  logic [SLOT_W-1:0]       pslot;
  logic [7:0]              orow;
  logic [7:0]              ocol;

  logic [ADDR_W-1:0] clr_addr;
  logic [KSEL_W-1:0] inj_m;
  win_t              win;

  logic accept;
  logic acc_pixel;
  logic acc_load;
  logic adv;
  logic complete;
  logic inj_last;
  logic chain_busy;

  // line memory: one word per column, one byte per buffered row
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [LINE_W-1:0] ram_wdata;
  logic [LINE_W-1:0] ram_rdata;
  logic [LINE_W-1:0] line_new;
  logic [MAX_KSIZE-1:0][PIX_W-1:0] column;

  tok_t             tok [CELLS+1];
  logic [CELLS-1:0] tok_valid;

  assign w_c = clamp_cnt(image_width, MAX_WIDTH);
  assign h_c = clamp_cnt(image_height, HEIGHT_LIMIT);
  assign kr  = clamp_ks(kernel_rows);
  assign kc  = clamp_ks(kernel_cols);
  assign kn  = clamp_kn(kernel_count);

  assign accept    = item_valid && !item_stall;
  assign acc_pixel = accept && (item.kind == KIND_PIXEL);
  assign acc_load  = accept && (item.kind == KIND_LOAD);
  assign adv       = !result_valid || !result_stall;

  // window is full once enough rows and columns are in
  assign complete = ({1'b0, pr} + 1'b1 >= {{(CNT_W+1-KS_W){1'b0}}, kr}) &&
                    ({1'b0, pc} + 1'b1 >= {{(CNT_W+1-KS_W){1'b0}}, kc});
  assign inj_last = (KN_W'(inj_m) + KN_W'(1)) == kn;
  assign chain_busy = |tok_valid;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CNT_W'(28);
      image_height <= CNT_W'(28);
      kernel_rows  <= 3'd3;
      kernel_cols  <= 3'd3;
      kernel_count <= 4'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        REG_KERNEL_ROWS:  kernel_rows  <= cfg_data[2:0];
        REG_KERNEL_COLS:  kernel_cols  <= cfg_data[2:0];
        REG_KERNEL_COUNT: kernel_count <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_CLEAR;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next    = st;
    item_stall = 1'b1;
    case (st)
      ST_CLEAR: begin
        if (clr_addr == ADDR_W'(MAX_WIDTH - 1)) st_next = ST_IDLE;
      end
      ST_IDLE: begin
        item_stall = 1'b0;
        if (acc_pixel) st_next = ST_READ;
      end
      ST_READ: begin
        st_next = complete ? ST_INJ : ST_IDLE;
      end
      ST_INJ: begin
        if (adv && inj_last) st_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!chain_busy) st_next = ST_IDLE;
      end
      default: st_next = ST_IDLE;
    endcase
  end

  // clearing sweep and kernel injection counters
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      inj_m    <= '0;
    end else begin
      if (st == ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (st == ST_READ) begin
        inj_m <= '0;
      end else if (st == ST_INJ && adv) begin
        inj_m <= inj_m + 1'b1;
      end
    end
  end

  // raster counters, cleared by a frame start and advanced as each pixel is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
      slot_base <= '0;
    end else if (accept && item.kind == KIND_FRAME) begin
      row_count <= '0;
      col_count <= '0;
      slot_base <= '0;
    end else if (acc_pixel) begin
      if ({1'b0, col_count} + 1'b1 >= {1'b0, w_c}) begin
        col_count <= '0;
        if ({1'b0, row_count} + 1'b1 >= {1'b0, h_c}) begin
          row_count <= '0;
          slot_base <= '0;
        end else begin
          row_count <= row_count + 1'b1;
          slot_base <= (slot_base == SLOT_W'(LINE_SLOTS - 1)) ? '0 : slot_base + 1'b1;
        end
      end else begin
        col_count <= col_count + 1'b1;
      end
    end
  end

  // pixel context
  always_ff @(posedge clk) begin
    if (acc_pixel) begin
      px    <= item.sample;
      pr    <= row_count;
      pc    <= col_count;
      pslot <= slot_base;
    end
    if (st == ST_READ) begin
      orow <= 8'({1'b0, pr} + 1'b1 - {{(CNT_W+1-KS_W){1'b0}}, kr});
      ocol <= 8'({1'b0, pc} + 1'b1 - {{(CNT_W+1-KS_W){1'b0}}, kc});
    end
  end

  // new window column: buffered rows oldest first, then the pixel
  always_comb begin
    int s;
    line_new = ram_rdata;
    column   = '0;
    for (int i = 0; i < MAX_KSIZE - 1; i++) begin
      s = int'(pslot) + i;
      if (s >= LINE_SLOTS) s = s - LINE_SLOTS;
      column[i] = ram_rdata[s*PIX_W +: PIX_W];
    end
    column[MAX_KSIZE-1] = px;
    line_new[int'(pslot)*PIX_W +: PIX_W] = px;
  end

  assign ram_we    = (st == ST_CLEAR) || (st == ST_READ && MAX_KSIZE > 1);
  assign ram_waddr = (st == ST_CLEAR) ? clr_addr : ADDR_W'(pc);
  assign ram_wdata = (st == ST_CLEAR) ? '0 : line_new;

  mkc_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ADDR_W'(col_count)),
    .rdata (ram_rdata)
  );

  // window shifts one column left, new column on the right
  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (st == ST_READ) begin
      for (int i = 0; i < MAX_KSIZE; i++) begin
        for (int j = 0; j < MAX_KSIZE - 1; j++) begin
          win[i][j] <= win[i][j+1];
        end
        win[i][MAX_KSIZE-1] <= column[i];
      end
    end
  end

  // one token per kernel enters the chain, sum starts at zero
  always_comb begin
    tok[0].valid = (st == ST_INJ);
    tok[0].map   = inj_m;
    tok[0].last  = inj_last;
    tok[0].sum   = '0;
  end

  // chain of mac cells, one per kernel tap; cell (k,l) sees the window tap
  // aligned to the bottom-right corner of the kernel
  for (genvar p = 0; p < CELLS; p++) begin : g_cell
    localparam int K = p / MAX_KSIZE;
    localparam int L = p % MAX_KSIZE;
    logic                    tap_en;
    logic [IDX_W-1:0]        ri;
    logic [IDX_W-1:0]        ci;
    logic signed [PIX_W-1:0] tap;
    wload_t                  wl;

    assign tap_en = (KS_W'(K) < kr) && (KS_W'(L) < kc);
    assign ri  = tap_en ? IDX_W'(MAX_KSIZE + K - int'(kr)) : '0;
    assign ci  = tap_en ? IDX_W'(MAX_KSIZE + L - int'(kc)) : '0;
    assign tap = $signed(win[ri][ci]);

    assign wl.en    = acc_load && (int'(item.weight_row) == K) &&
                      (int'(item.weight_col) == L) && (int'(item.kernel_sel) < MAX_KERNELS);
    assign wl.sel   = KSEL_W'(item.kernel_sel);
    assign wl.value = item.sample;

    mkc_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .tap_en  (tap_en),
      .tap     (tap),
      .wl      (wl),
      .tok_in  (tok[p]),
      .tok_out (tok[p+1])
    );

    assign tok_valid[p] = tok[p+1].valid;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= tok[CELLS].valid;
    end
    if (adv) begin
      result.map_index <= 3'(tok[CELLS].map);
      result.out_row   <= orow;
      result.out_col   <= ocol;
      result.dot_sum   <= tok[CELLS].sum;
      result.last      <= tok[CELLS].last;
    end
  end

  // a pixel only enters with the chain empty
  a_pixel_chain_empty: assert property (@(posedge clk) disable iff (rst)
    acc_pixel |-> !chain_busy)
    else $error("pixel taken while chain busy");

  // window holds while kernel sums are being formed
  a_win_hold: assert property (@(posedge clk) disable iff (rst)
    (st == ST_INJ || st == ST_DRAIN) |=> $stable(win))
    else $error("window moved under active sums");

  // never more tokens in flight than kernels
  a_tok_count: assert property (@(posedge clk) disable iff (rst)
    $countones(tok_valid) <= MAX_KERNELS)
    else $error("too many tokens in chain");

  // a frozen chain injects nothing new
  a_inj_hold: assert property (@(posedge clk) disable iff (rst)
    (st == ST_INJ && !adv) |=> $stable(inj_m))
    else $error("injection advanced during stall");

endmodule
